/* rtl/core/multi_voice_sample_mixer_defines.svh */
// assertion macros used by the mixer top level
`ifndef MULTI_VOICE_SAMPLE_MIXER_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst is high
`define MVSM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on clk, off while rst is high
`define MVSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/mvsm_pkg.sv */
// shared constants, types and codes of the voice mixer
`timescale 1ns / 1ps

package mvsm_pkg;

  localparam int MAX_VOICES   = 8;
  localparam int SAMPLE_WORDS = 65536;

  localparam int AW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  // number of compare and subtract steps that bring a 16-bit address below SAMPLE_WORDS
  function automatic int mod_steps_f();
    int n;
    longint d;
    n = 0;
    for (int k = 0; k < 17; k++) begin
      d = longint'(SAMPLE_WORDS) << k;
      if (d <= 65535) n = k + 1;
    end
    return n;
  endfunction

  localparam int MOD_STEPS = mod_steps_f();
  localparam int MSW       = $clog2(MOD_STEPS + 2);

  // largest shifted divisor, the first one tried
  function automatic logic [15:0] mod_top_f();
    logic [15:0] top;
    top = 16'd0;
    for (int k = 0; k < 17; k++) begin
      if (k + 1 == MOD_STEPS) top = 16'(longint'(SAMPLE_WORDS) << k);
    end
    return top;
  endfunction

  localparam logic [15:0]   MOD_TOP  = mod_top_f();
  localparam logic [AW-1:0] WORD_MAX = AW'(SAMPLE_WORDS - 1);

  localparam logic signed [15:0] SAT_HI = 16'sh7FFF;
  localparam logic signed [15:0] SAT_LO = -16'sh8000;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_START = 2'd1;
  localparam op_t OP_MIX   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOAD,
    ST_START,
    ST_MIX_READ,
    ST_MIX_MUL,
    ST_MIX_ACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [15:0]   wdata;
  } ram_req_t;

endpackage

/* rtl/core/mvsm_sample_ram.sv */
// single-port sample memory with registered read
`timescale 1ns / 1ps

module mvsm_sample_ram
  import mvsm_pkg::*;
(
  input  logic        clk,
  input  ram_req_t    req,
  output logic [15:0] rdata
);

  logic [15:0] mem [SAMPLE_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

/* rtl/core/multi_voice_sample_mixer.sv */
// top level of the sample voice mixer: sequencer, voice table and shared multiplier
//
// items come in on the item channel (item_valid / item_stall) with an op code:
//   load  writes sample_word at address (modulo the memory size)
//   start claims the next voice slot with address, sound_length and gain;
//         with every slot busy start_refused is set instead
//   mix   adds every playing voice, oldest first, onto music_sample with
//         saturation after each voice; a voice is freed after its last word
// each item gives exactly one result on the result channel (result_valid /
// result_stall): mixed_sample (zero unless mix), start_refused, active_voices
// one item is worked at a time; item_stall is high from acceptance until the
// result is written into the output register
// load and start first bring the address below the memory size by MOD_STEPS compare
// and subtract steps (MOD_STEPS is 0 with a 64k word memory); mix reads, multiplies
// and accumulates each playing voice with words left in turn through the single memory
// port and the one multiplier, and frees a voice of zero length without a memory visit
// the output register frees the sequencer: a next item is taken while a result
// waits, and only the write of its own result holds while result_stall is high
// rst clears the sequencer, the voice count and result_valid; sample memory
// contents are undefined until written and get no clearing pass
`timescale 1ns / 1ps
`include "multi_voice_sample_mixer_defines.svh"

module multi_voice_sample_mixer
  import mvsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         op,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample_word,
  input  logic [16:0]        sound_length,
  input  logic [11:0]        gain,
  input  logic signed [15:0] music_sample,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] mixed_sample,
  output logic               start_refused,
  output logic [3:0]         active_voices
);

  state_t state, state_next;

  // latched request
  op_t         req_op;
  logic [15:0] req_address;
  logic [15:0] req_word;
  logic [16:0] req_length;
  logic [11:0] req_gain;

  // address reduction unit
  logic [15:0]    mod_rem;
  logic [15:0]    mod_div;
  logic [MSW-1:0] mod_step;

  // voice table, oldest voice at slot zero
  logic [15:0]   voice_address   [MAX_VOICES];
  logic [16:0]   voice_remaining [MAX_VOICES];
  logic [11:0]   voice_gain      [MAX_VOICES];
  logic [AW-1:0] voice_index     [MAX_VOICES];
  logic [CW-1:0] voice_count;

  // mix walk
  logic [CW-1:0]      visit;
  logic [CW-1:0]      kept;
  logic [15:0]        cur_address;
  logic [16:0]        cur_remaining;
  logic [11:0]        cur_gain;
  logic [AW-1:0]      cur_index;
  logic signed [28:0] product;
  logic signed [15:0] acc;
  logic               refused;

  ram_req_t    ram_req;
  logic [15:0] ram_rdata;

  logic               result_free;
  logic               slot_free;
  logic               visit_done;
  logic [IW-1:0]      visit_slot;
  logic signed [28:0] product_biased;
  logic signed [20:0] scaled;
  logic signed [21:0] sum;
  logic signed [15:0] sum_sat;
  logic [16:0]        remaining_left;
  logic [AW-1:0]      index_step;

  assign result_free = !result_valid || !result_stall;
  assign slot_free   = voice_count < CW'(MAX_VOICES);
  assign visit_done  = visit == voice_count;
  assign visit_slot  = visit[IW-1:0];

  mvsm_sample_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // scale by gain and divide by 256 toward zero, then saturate the running mix
  always_comb begin
    product_biased = product + (product[28] ? 29'sd255 : 29'sd0);
    scaled         = product_biased[28:8];
    sum            = {{6{acc[15]}}, acc} + {scaled[20], scaled};
    if (sum > 22'sd32767) begin
      sum_sat = SAT_HI;
    end else if (sum < -22'sd32768) begin
      sum_sat = SAT_LO;
    end else begin
      sum_sat = sum[15:0];
    end
    remaining_left = cur_remaining - 17'd1;
    // memory index follows the address: back to zero at the end of memory or on address wrap
    if (cur_address == 16'hFFFF || cur_index == WORD_MAX) begin
      index_step = '0;
    end else begin
      index_step = cur_index + AW'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (op == OP_LOAD || op == OP_START) begin
            if (MOD_STEPS > 0) begin
              state_next = ST_MOD;
            end else if (op == OP_LOAD) begin
              state_next = ST_LOAD;
            end else begin
              state_next = ST_START;
            end
          end else if (op == OP_MIX) begin
            state_next = ST_MIX_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MOD: begin
        if (mod_step == MSW'(1)) begin
          state_next = (req_op == OP_LOAD) ? ST_LOAD : ST_START;
        end
      end
      ST_LOAD:  state_next = ST_FINISH;
      ST_START: state_next = ST_FINISH;
      ST_MIX_READ: begin
        if (visit_done) begin
          state_next = ST_FINISH;
        end else if (voice_remaining[visit_slot] != 17'd0) begin
          state_next = ST_MIX_MUL;
        end
      end
      ST_MIX_MUL: state_next = ST_MIX_ACC;
      ST_MIX_ACC: state_next = ST_MIX_READ;
      ST_FINISH: begin
        if (result_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall    = state != ST_IDLE;
    ram_req.we    = 1'b0;
    ram_req.addr  = voice_index[visit_slot];
    ram_req.wdata = req_word;
    case (state)
      ST_LOAD: begin
        ram_req.we   = 1'b1;
        ram_req.addr = AW'(mod_rem);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control: voice count and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_START && slot_free) begin
        voice_count <= voice_count + CW'(1);
      end
      if (state == ST_MIX_READ && visit_done) begin
        voice_count <= kept;
      end
      if (state == ST_FINISH && result_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          req_op      <= op;
          req_address <= address;
          req_word    <= sample_word;
          req_length  <= sound_length;
          req_gain    <= gain;
          mod_rem     <= address;
          mod_div     <= MOD_TOP;
          mod_step    <= MSW'(MOD_STEPS);
          visit       <= '0;
          kept        <= '0;
          refused     <= 1'b0;
          acc         <= (op == OP_MIX) ? music_sample : 16'sd0;
        end
      end
      ST_MOD: begin
        if (mod_rem >= mod_div) mod_rem <= mod_rem - mod_div;
        mod_div  <= mod_div >> 1;
        mod_step <= mod_step - MSW'(1);
      end
      ST_START: begin
        if (slot_free) begin
          voice_address[voice_count[IW-1:0]]   <= req_address;
          voice_remaining[voice_count[IW-1:0]] <= req_length;
          voice_gain[voice_count[IW-1:0]]      <= req_gain;
          voice_index[voice_count[IW-1:0]]     <= AW'(mod_rem);
        end else begin
          refused <= 1'b1;
        end
      end
      ST_MIX_READ: begin
        if (!visit_done) begin
          cur_address   <= voice_address[visit_slot];
          cur_remaining <= voice_remaining[visit_slot];
          cur_gain      <= voice_gain[visit_slot];
          cur_index     <= voice_index[visit_slot];
          // zero length voice: freed without a visit to memory
          if (voice_remaining[visit_slot] == 17'd0) visit <= visit + CW'(1);
        end
      end
      ST_MIX_MUL: begin
        product <= 29'(signed'(ram_rdata)) * 29'(signed'({1'b0, cur_gain}));
      end
      ST_MIX_ACC: begin
        acc   <= sum_sat;
        visit <= visit + CW'(1);
        if (remaining_left != 17'd0) begin
          voice_address[kept[IW-1:0]]   <= cur_address + 16'd1;
          voice_remaining[kept[IW-1:0]] <= remaining_left;
          voice_gain[kept[IW-1:0]]      <= cur_gain;
          voice_index[kept[IW-1:0]]     <= index_step;
          kept                          <= kept + CW'(1);
        end
      end
      ST_FINISH: begin
        if (result_free) begin
          mixed_sample  <= acc;
          start_refused <= refused;
          active_voices <= 4'(voice_count);
        end
      end
      default: begin
      end
    endcase
  end

  `MVSM_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall,
    "request accepted but block not busy")
  `MVSM_ASSERT_NOW(a_count_bound, 1'b1, voice_count <= CW'(MAX_VOICES),
    "voice count above slot count")
  `MVSM_ASSERT_NOW(a_acc_has_words, state == ST_MIX_ACC, cur_remaining != 17'd0,
    "voice with no words reached accumulate")
  `MVSM_ASSERT_NEXT(a_finish_delivers, state == ST_FINISH && result_free, result_valid,
    "finished request produced no result")

endmodule
